// ----- hdl/shc_pkg.sv -----
package shc_pkg;

  localparam int HALF_W         = 16;
  localparam int PROD_W         = 2 * HALF_W;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_FLAGS      = 5;
  localparam int COORD_BITS_DEF = 16;

  // Register stages from request to result strobe
  localparam int ASP_STAGES = 5 + 2 * PROD_W;
  localparam int LATENCY    = 3 + HALF_W + 1 + 2 * ASP_STAGES + 1;

  localparam int FLAG_MIN  = 0;
  localparam int FLAG_MAX  = 1;
  localparam int FLAG_INC  = 2;
  localparam int FLAG_ASP  = 3;
  localparam int FLAG_BASE = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HINT_FLAGS,
    REG_MIN_SIZE,
    REG_BASE_SIZE,
    REG_HINT_MAX,
    REG_SCREEN_MAX,
    REG_INCREMENT,
    REG_MIN_ASPECT,
    REG_MAX_ASPECT
  } cfg_reg_t;

  typedef logic [HALF_W-1:0] half_t;

  // Settings for one aspect check, seen from the axis that grows (u)
  // and the axis that shrinks (v)
  typedef struct packed {
    logic  en;
    half_t g;
    half_t k;
    half_t inc_u;
    half_t inc_v;
    half_t max_u;
    half_t min_v;
  } asp_cfg_t;

  function automatic half_t lo_half(logic [CFG_W-1:0] r);
    return r[HALF_W-1:0];
  endfunction

  function automatic half_t hi_half(logic [CFG_W-1:0] r);
    return r[CFG_W-1:HALF_W];
  endfunction

endpackage

// ----- hdl/shc_div_pair.sv -----
module shc_div_pair #(
  parameter int NUM_W = 32,
  parameter int TAG_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [NUM_W-1:0]    num_a,
  input  logic [NUM_W-1:0]    num_b,
  input  shc_pkg::half_t      den_a,
  input  shc_pkg::half_t      den_b,
  input  logic [TAG_W-1:0]    tag_in,
  output logic                out_valid,
  output logic [NUM_W-1:0]    quo_a,
  output logic [NUM_W-1:0]    quo_b,
  output shc_pkg::half_t      rem_a,
  output shc_pkg::half_t      rem_b,
  output logic [TAG_W-1:0]    tag_out
);
  import shc_pkg::*;

  // One quotient bit per stage; the user must hold divisors still while requests are in flight (not enforced)
  logic             vld [1:NUM_W];
  half_t            ra  [1:NUM_W];
  half_t            rb  [1:NUM_W];
  logic [NUM_W-1:0] aa  [1:NUM_W];
  logic [NUM_W-1:0] ab  [1:NUM_W];
  logic [TAG_W-1:0] tg  [1:NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             s_vld;
    half_t            s_ra, s_rb;
    logic [NUM_W-1:0] s_aa, s_ab;
    logic [TAG_W-1:0] s_tg;
    logic [HALF_W:0]  ta, tb;
    logic             ga, gb;

    if (i == 0) begin : g_first
      assign s_vld = in_valid;
      assign s_ra  = '0;
      assign s_rb  = '0;
      assign s_aa  = num_a;
      assign s_ab  = num_b;
      assign s_tg  = tag_in;
    end else begin : g_next
      assign s_vld = vld[i];
      assign s_ra  = ra[i];
      assign s_rb  = rb[i];
      assign s_aa  = aa[i];
      assign s_ab  = ab[i];
      assign s_tg  = tg[i];
    end

    assign ta = {s_ra, s_aa[NUM_W-1]};
    assign tb = {s_rb, s_ab[NUM_W-1]};
    assign ga = (ta >= {1'b0, den_a});
    assign gb = (tb >= {1'b0, den_b});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      ra[i+1] <= ga ? HALF_W'(ta - {1'b0, den_a}) : ta[HALF_W-1:0];
      rb[i+1] <= gb ? HALF_W'(tb - {1'b0, den_b}) : tb[HALF_W-1:0];
      aa[i+1] <= {s_aa[NUM_W-2:0], ga};
      ab[i+1] <= {s_ab[NUM_W-2:0], gb};
      tg[i+1] <= s_tg;
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo_a     = aa[NUM_W];
  assign quo_b     = ab[NUM_W];
  assign rem_a     = ra[NUM_W];
  assign rem_b     = rb[NUM_W];
  assign tag_out   = tg[NUM_W];

endmodule

// ----- hdl/shc_aspect.sv -----
module shc_aspect #(
  parameter int CTX_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  shc_pkg::half_t     u_in,
  input  shc_pkg::half_t     v_in,
  input  logic [CTX_W-1:0]   ctx_in,
  input  shc_pkg::asp_cfg_t  cfg,
  output logic               out_valid,
  output shc_pkg::half_t     u_out,
  output shc_pkg::half_t     v_out,
  output logic [CTX_W-1:0]   ctx_out
);
  import shc_pkg::*;

  localparam int TAG_W = CTX_W + 2 * HALF_W + 1;

  // Products
  logic              v1;
  half_t             u1, w1;
  logic [CTX_W-1:0]  c1;
  logic [PROD_W-1:0] p_gv1, p_ku1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    u1    <= u_in;
    w1    <= v_in;
    c1    <= ctx_in;
    p_gv1 <= PROD_W'(cfg.g) * PROD_W'(v_in);
    p_ku1 <= PROD_W'(cfg.k) * PROD_W'(u_in);
  end

  // Ratio test
  logic              v2, cond2;
  half_t             u2, w2;
  logic [CTX_W-1:0]  c2;
  logic [PROD_W-1:0] p_gv2, p_ku2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    u2    <= u1;
    w2    <= w1;
    c2    <= c1;
    p_gv2 <= p_gv1;
    p_ku2 <= p_ku1;
    cond2 <= cfg.en && (p_gv1 > p_ku1);
  end

  // Target sizes on both axes
  logic              vq;
  logic [PROD_W-1:0] q_u, q_v;
  logic [TAG_W-1:0]  tag_q;

  shc_div_pair #(.NUM_W(PROD_W), .TAG_W(TAG_W)) u_div_ratio (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .num_a     (p_gv2),
    .num_b     (p_ku2),
    .den_a     (cfg.k),
    .den_b     (cfg.g),
    .tag_in    ({c2, u2, w2, cond2}),
    .out_valid (vq),
    .quo_a     (q_u),
    .quo_b     (q_v),
    .rem_a     (),
    .rem_b     (),
    .tag_out   (tag_q)
  );

  // Raw corrections
  logic              v3;
  logic [TAG_W-1:0]  tag3;
  logic [PROD_W-1:0] d_u3, d_v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= vq;
    end
  end

  always_ff @(posedge clk) begin
    tag3 <= tag_q;
    d_u3 <= q_u - PROD_W'(tag_q[2*HALF_W:HALF_W+1]);
    d_v3 <= PROD_W'(tag_q[HALF_W:1]) - q_v;
  end

  // Snap corrections to the increments
  logic              vs;
  logic [PROD_W-1:0] s_u, s_v;
  logic [TAG_W-1:0]  tag_s;

  shc_div_pair #(.NUM_W(PROD_W), .TAG_W(TAG_W)) u_div_snap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .num_a     (d_u3),
    .num_b     (d_v3),
    .den_a     (cfg.inc_u),
    .den_b     (cfg.inc_v),
    .tag_in    (tag3),
    .out_valid (vs),
    .quo_a     (s_u),
    .quo_b     (s_v),
    .rem_a     (),
    .rem_b     (),
    .tag_out   (tag_s)
  );

  logic              v4;
  logic [TAG_W-1:0]  tag4;
  logic [PROD_W-1:0] d_u4, d_v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= vs;
    end
  end

  always_ff @(posedge clk) begin
    tag4 <= tag_s;
    d_u4 <= s_u * PROD_W'(cfg.inc_u);
    d_v4 <= s_v * PROD_W'(cfg.inc_v);
  end

  // Apply: grow u if it stays within its maximum, else shrink v if it keeps its minimum and g is nonzero
  half_t            u4, w4;
  logic             cond4, fit_u, fit_v, take_u, take_v;
  logic [CTX_W-1:0] c4;

  always_comb begin
    {c4, u4, w4, cond4} = tag4;
    fit_u  = ({1'b0, d_u4} + (PROD_W+1)'(u4)) <= (PROD_W+1)'(cfg.max_u);
    fit_v  = ({1'b0, d_v4} + (PROD_W+1)'(cfg.min_v)) <= (PROD_W+1)'(w4);
    take_u = cond4 && fit_u;
    take_v = cond4 && !fit_u && (cfg.g != '0) && fit_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    u_out   <= take_u ? u4 + d_u4[HALF_W-1:0] : u4;
    v_out   <= take_v ? w4 - d_v4[HALF_W-1:0] : w4;
    ctx_out <= c4;
  end

endmodule

// ----- hdl/size_hint_constrain_unit.sv -----
// Size hint constraint unit.
// Request channel: drive req_width, req_height (frame height including the
// title bar) and title_size with start high; the request is taken at a
// rising edge where start is high and busy is low. busy is high only while
// rst is high, so a new request may be taken in every clock cycle.
// Result channel: done pulses for one cycle with fit_width and fit_height,
// the size after minimum, maximum, increment and aspect hints, saturated to
// 0 .. 2^COORD_BITS-1. Results leave in request order, one per request.
// From request to result: clamping and sign handling take three stages,
// the increment snap a 16-stage divider and one stage to rebuild the size,
// each aspect check two 32-stage dividers in series plus five stages, and
// the title add with saturation one stage.
// Throughput is one request per cycle; every divider is fully pipelined.
// Hint registers are written through cfg_write / cfg_index / cfg_data and
// take effect at once; write them only with no request in flight.
// Reset (synchronous, active high) drops all requests in flight and loads
// the hint registers with their reset values. The receiver cannot stall:
// a result is present on the ports for its strobe cycle only.
module size_hint_constrain_unit #(
  parameter int COORD_BITS = shc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         req_width,
  input  logic [COORD_BITS-1:0]         req_height,
  input  logic [COORD_BITS-1:0]         title_size,
  input  logic                          cfg_write,
  input  logic [shc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shc_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output logic [COORD_BITS-1:0]         fit_width,
  output logic [COORD_BITS-1:0]         fit_height
);
  import shc_pkg::*;

  localparam int WIDE = PROD_W + 1;
  localparam logic [WIDE-1:0] COORD_MAX = (WIDE'(1) << COORD_BITS) - WIDE'(1);

  // Hint registers
  logic [NUM_FLAGS-1:0] hint_flags;
  logic [CFG_W-1:0]     min_size, base_size, hint_max_size, screen_max_size;
  logic [CFG_W-1:0]     size_increment, min_ratio, max_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      hint_flags      <= '0;
      min_size        <= '0;
      base_size       <= '0;
      hint_max_size   <= '1;
      screen_max_size <= '1;
      size_increment  <= {HALF_W'(1), HALF_W'(1)};
      min_ratio       <= '0;
      max_ratio       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HINT_FLAGS: hint_flags      <= cfg_data[NUM_FLAGS-1:0];
        REG_MIN_SIZE:   min_size        <= cfg_data;
        REG_BASE_SIZE:  base_size       <= cfg_data;
        REG_HINT_MAX:   hint_max_size   <= cfg_data;
        REG_SCREEN_MAX: screen_max_size <= cfg_data;
        REG_INCREMENT:  size_increment  <= cfg_data;
        REG_MIN_ASPECT: min_ratio       <= cfg_data;
        REG_MAX_ASPECT: max_ratio       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective limits; the user must keep them still while requests are in flight (not enforced)
  half_t     minw, minh, basew, baseh, maxw, maxh, xinc, yinc;
  asp_cfg_t  asp_min_cfg, asp_max_cfg;

  always_comb begin
    if (hint_flags[FLAG_MIN]) begin
      minw = lo_half(min_size);
      minh = hi_half(min_size);
    end else if (hint_flags[FLAG_BASE]) begin
      minw = lo_half(base_size);
      minh = hi_half(base_size);
    end else begin
      minw = HALF_W'(1);
      minh = HALF_W'(1);
    end

    if (hint_flags[FLAG_BASE]) begin
      basew = lo_half(base_size);
      baseh = hi_half(base_size);
    end else if (hint_flags[FLAG_MIN]) begin
      basew = lo_half(min_size);
      baseh = hi_half(min_size);
    end else begin
      basew = '0;
      baseh = '0;
    end

    maxw = lo_half(screen_max_size);
    maxh = hi_half(screen_max_size);
    if (hint_flags[FLAG_MAX]) begin
      if (lo_half(hint_max_size) < maxw) maxw = lo_half(hint_max_size);
      if (hi_half(hint_max_size) < maxh) maxh = hi_half(hint_max_size);
    end

    xinc = HALF_W'(1);
    yinc = HALF_W'(1);
    if (hint_flags[FLAG_INC]) begin
      if (lo_half(size_increment) != '0) xinc = lo_half(size_increment);
      if (hi_half(size_increment) != '0) yinc = hi_half(size_increment);
    end

    // Minimum ratio: widen first, else shorten
    asp_min_cfg.en    = hint_flags[FLAG_ASP] && (hi_half(min_ratio) != '0);
    asp_min_cfg.g     = lo_half(min_ratio);
    asp_min_cfg.k     = hi_half(min_ratio);
    asp_min_cfg.inc_u = xinc;
    asp_min_cfg.inc_v = yinc;
    asp_min_cfg.max_u = maxw;
    asp_min_cfg.min_v = minh;

    // Maximum ratio: heighten first, else narrow
    asp_max_cfg.en    = hint_flags[FLAG_ASP] && (lo_half(max_ratio) != '0)
                        && (hi_half(max_ratio) != '0);
    asp_max_cfg.g     = hi_half(max_ratio);
    asp_max_cfg.k     = lo_half(max_ratio);
    asp_max_cfg.inc_u = yinc;
    asp_max_cfg.inc_v = xinc;
    asp_max_cfg.max_u = maxh;
    asp_max_cfg.min_v = minw;
  end

  assign busy = rst;

  // Stage 1: take the request, remove the title from the height
  logic                         v1;
  logic [COORD_BITS-1:0]        w1, t1;
  logic signed [COORD_BITS:0]   h1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    w1 <= req_width;
    t1 <= title_size;
    h1 <= $signed({1'b0, req_height}) - $signed({1'b0, title_size});
  end

  // Stage 2: clamp to minimum, then maximum (maximum wins)
  logic                      v2;
  half_t                     w2, h2;
  logic [COORD_BITS-1:0]     t2;
  logic [PROD_W-1:0]         wx, wlo;
  logic signed [WIDE-1:0]    hx, hlo;

  always_comb begin
    wx  = PROD_W'(w1);
    wlo = (wx < PROD_W'(minw)) ? PROD_W'(minw) : wx;
    hx  = WIDE'(h1);
    hlo = (hx < $signed(WIDE'(minh))) ? $signed(WIDE'(minh)) : hx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    t2 <= t1;
    w2 <= (wlo > PROD_W'(maxw)) ? maxw : wlo[HALF_W-1:0];
    h2 <= (hlo > $signed(WIDE'(maxh))) ? maxh : hlo[HALF_W-1:0];
  end

  // Stage 3: offset from the base as sign and magnitude
  logic                  v3, sw3, sh3;
  half_t                 mw3, mh3;
  logic [COORD_BITS-1:0] t3;
  logic [HALF_W:0]       dw, dh;

  always_comb begin
    dw = {1'b0, w2} - {1'b0, basew};
    dh = {1'b0, h2} - {1'b0, baseh};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    t3  <= t2;
    sw3 <= dw[HALF_W];
    sh3 <= dh[HALF_W];
    mw3 <= dw[HALF_W] ? HALF_W'(-dw) : dw[HALF_W-1:0];
    mh3 <= dh[HALF_W] ? HALF_W'(-dh) : dh[HALF_W-1:0];
  end

  // Increment snap: keep magnitude minus remainder, truncating toward the base
  logic                       vd;
  half_t                      rw, rh;
  logic [COORD_BITS+2*HALF_W+1:0] tag_d;

  shc_div_pair #(.NUM_W(HALF_W), .TAG_W(COORD_BITS + 2 * HALF_W + 2)) u_div_inc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .num_a     (mw3),
    .num_b     (mh3),
    .den_a     (xinc),
    .den_b     (yinc),
    .tag_in    ({t3, sw3, sh3, mw3, mh3}),
    .out_valid (vd),
    .quo_a     (),
    .quo_b     (),
    .rem_a     (rw),
    .rem_b     (rh),
    .tag_out   (tag_d)
  );

  logic                  sw_d, sh_d;
  half_t                 mw_d, mh_d, kw, kh;
  logic [COORD_BITS-1:0] t_d;

  always_comb begin
    {t_d, sw_d, sh_d, mw_d, mh_d} = tag_d;
    kw = mw_d - rw;
    kh = mh_d - rh;
  end

  logic                  v4;
  half_t                 w4, h4;
  logic [COORD_BITS-1:0] t4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    t4 <= t_d;
    w4 <= sw_d ? basew - kw : basew + kw;
    h4 <= sh_d ? baseh - kh : baseh + kh;
  end

  // Minimum aspect: u is width, v is height
  logic                  v5;
  half_t                 w5, h5;
  logic [COORD_BITS-1:0] t5;

  shc_aspect #(.CTX_W(COORD_BITS)) u_asp_min (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .u_in      (w4),
    .v_in      (h4),
    .ctx_in    (t4),
    .cfg       (asp_min_cfg),
    .out_valid (v5),
    .u_out     (w5),
    .v_out     (h5),
    .ctx_out   (t5)
  );

  // Maximum aspect: u is height, v is width
  logic                  v6;
  half_t                 w6, h6;
  logic [COORD_BITS-1:0] t6;

  shc_aspect #(.CTX_W(COORD_BITS)) u_asp_max (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .u_in      (h5),
    .v_in      (w5),
    .ctx_in    (t5),
    .cfg       (asp_max_cfg),
    .out_valid (v6),
    .u_out     (h6),
    .v_out     (w6),
    .ctx_out   (t6)
  );

  // Output: add the title back and saturate
  logic [WIDE-1:0] w_sum, h_sum;

  always_comb begin
    w_sum = WIDE'(w6);
    h_sum = WIDE'(h6) + WIDE'(t6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    fit_width  <= (w_sum > COORD_MAX) ? '1 : w_sum[COORD_BITS-1:0];
    fit_height <= (h_sum > COORD_MAX) ? '1 : h_sum[COORD_BITS-1:0];
  end

endmodule

// ----- hdl/shc_check.sv -----
module shc_check #(
  parameter int COORD_BITS = shc_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [COORD_BITS-1:0] title_size,
  input logic                  done,
  input logic [COORD_BITS-1:0] fit_height
);
  import shc_pkg::*;

  // Reset drops every request in flight
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // Every request yields a result
  a_result_due: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after request");

  // No result without a matching earlier request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  // The height with title never falls below the title itself
  a_title_kept: assert property (@(posedge clk) disable iff (rst)
    done |-> (fit_height >= $past(title_size, LATENCY)))
    else $error("height below title");

endmodule

bind size_hint_constrain_unit shc_check #(.COORD_BITS(COORD_BITS)) u_shc_check (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .title_size (title_size),
  .done       (done),
  .fit_height (fit_height)
);

// ----- tb/sv/size_hint_constrain_unit_tb.sv -----
module size_hint_constrain_unit_tb;
  import shc_pkg::*;

  localparam int CB = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [CB-1:0] width;
    logic [CB-1:0] height;
  } fit_size_t;

  // Expected-size store with its own copy of the hint registers
  class size_hint_scoreboard;
    logic [31:0] regs [8];
    fit_size_t   pending_sizes[$];
    int          mismatches;

    function void clear_regs();
      regs[REG_HINT_FLAGS] = '0;
      regs[REG_MIN_SIZE]   = '0;
      regs[REG_BASE_SIZE]  = '0;
      regs[REG_HINT_MAX]   = '1;
      regs[REG_SCREEN_MAX] = '1;
      regs[REG_INCREMENT]  = 32'h0001_0001;
      regs[REG_MIN_ASPECT] = '0;
      regs[REG_MAX_ASPECT] = '0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] val);
      regs[idx] = (idx == REG_HINT_FLAGS) ? (val & 32'h1f) : val;
    endfunction

    function longint lo(logic [31:0] r);
      return longint'(r[15:0]);
    endfunction

    function longint hi(logic [31:0] r);
      return longint'(r[31:16]);
    endfunction

    function longint snap(longint a, longint step);
      return (a / step) * step;
    endfunction

    function logic [CB-1:0] clip(longint v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return v[CB-1:0];
    endfunction

    function fit_size_t fit_request(logic [CB-1:0] rw, logic [CB-1:0] rh,
                                    logic [CB-1:0] ts);
      logic [4:0] fl;
      longint w, h, t, minw, minh, basew, baseh, maxw, maxh, xi, yi, d, ax, ay;
      fit_size_t r;
      fl = regs[REG_HINT_FLAGS][4:0];
      t = ts;
      w = rw;
      h = longint'(rh) - t;
      if (fl[FLAG_MIN]) begin
        minw = lo(regs[REG_MIN_SIZE]); minh = hi(regs[REG_MIN_SIZE]);
      end else if (fl[FLAG_BASE]) begin
        minw = lo(regs[REG_BASE_SIZE]); minh = hi(regs[REG_BASE_SIZE]);
      end else begin
        minw = 1; minh = 1;
      end
      if (fl[FLAG_BASE]) begin
        basew = lo(regs[REG_BASE_SIZE]); baseh = hi(regs[REG_BASE_SIZE]);
      end else if (fl[FLAG_MIN]) begin
        basew = lo(regs[REG_MIN_SIZE]); baseh = hi(regs[REG_MIN_SIZE]);
      end else begin
        basew = 0; baseh = 0;
      end
      maxw = lo(regs[REG_SCREEN_MAX]);
      maxh = hi(regs[REG_SCREEN_MAX]);
      if (fl[FLAG_MAX]) begin
        if (lo(regs[REG_HINT_MAX]) < maxw) maxw = lo(regs[REG_HINT_MAX]);
        if (hi(regs[REG_HINT_MAX]) < maxh) maxh = hi(regs[REG_HINT_MAX]);
      end
      xi = 1;
      yi = 1;
      if (fl[FLAG_INC]) begin
        xi = lo(regs[REG_INCREMENT]);
        yi = hi(regs[REG_INCREMENT]);
        if (xi == 0) xi = 1;
        if (yi == 0) yi = 1;
      end
      if (w < minw) w = minw;
      if (h < minh) h = minh;
      if (w > maxw) w = maxw;
      if (h > maxh) h = maxh;
      w = snap(w - basew, xi) + basew;
      h = snap(h - baseh, yi) + baseh;
      if (fl[FLAG_ASP]) begin
        ax = lo(regs[REG_MIN_ASPECT]);
        ay = hi(regs[REG_MIN_ASPECT]);
        if (ay != 0 && ax * h > ay * w) begin
          d = snap(ax * h / ay - w, xi);
          if (w + d <= maxw) begin
            w += d;
          end else if (ax != 0) begin
            d = snap(h - w * ay / ax, yi);
            if (h - d >= minh) h -= d;
          end
        end
        ax = lo(regs[REG_MAX_ASPECT]);
        ay = hi(regs[REG_MAX_ASPECT]);
        if (ax != 0 && ay != 0 && ax * h < ay * w) begin
          d = snap(w * ay / ax - h, yi);
          if (h + d <= maxh) begin
            h += d;
          end else begin
            d = snap(w - ax * h / ay, xi);
            if (w - d >= minw) w -= d;
          end
        end
      end
      r.width = clip(w);
      r.height = clip(h + t);
      return r;
    endfunction

    function void note_request(logic [CB-1:0] rw, logic [CB-1:0] rh, logic [CB-1:0] ts);
      pending_sizes.push_back(fit_request(rw, rh, ts));
    endfunction

    function void check_result(logic [CB-1:0] fw, logic [CB-1:0] fh);
      fit_size_t e;
      if (pending_sizes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result w=%0d h=%0d", fw, fh);
        return;
      end
      e = pending_sizes.pop_front();
      if (fw !== e.width || fh !== e.height) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected w=%0d h=%0d, got w=%0d h=%0d",
                   e.width, e.height, fw, fh);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, cfg_write, done;
  logic [CB-1:0] req_width, req_height, title_size, fit_width, fit_height;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  size_hint_scoreboard sizes_sb;
  int idle_cycles;

  size_hint_constrain_unit #(.COORD_BITS(CB)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_width(req_width), .req_height(req_height), .title_size(title_size),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .fit_width(fit_width), .fit_height(fit_height)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample at the rising edge: score requests taken and results strobed,
  // and count cycles with no traffic for the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sizes_sb.note_request(req_width, req_height, title_size);
      if (done) sizes_sb.check_result(fit_width, fit_height);
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Write one hint register; only called with nothing in flight
  task automatic write_hint(cfg_reg_t idx, logic [31:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    sizes_sb.set_reg(idx, val);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Present one request and hold it until taken; keep start high for the
  // next request rather than dropping it, so a burst runs back to back
  task automatic send_request(logic [CB-1:0] rw, logic [CB-1:0] rh, logic [CB-1:0] ts,
                              bit keep_start);
    start = 1'b1;
    req_width = rw;
    req_height = rh;
    title_size = ts;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (!keep_start) start = 1'b0;
  endtask

  // Drain: wait for every expected result, then let the pipeline settle
  task automatic drain_results();
    while (sizes_sb.pending_sizes.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Pick a small-ish or extreme size component
  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hffff - 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(0, 64));
      3: return 16'($urandom_range(0, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_pair();
    return {pick_half(), pick_half()};
  endfunction

  // Random request, mostly plausible window sizes, some wide noise
  task automatic random_request(bit keep_start);
    logic [CB-1:0] rw, rh, ts;
    if ($urandom_range(0, 3) != 0) begin
      rw = 16'($urandom_range(0, 3000));
      rh = 16'($urandom_range(0, 3000));
      ts = 16'($urandom_range(0, 40));
    end else begin
      rw = pick_half();
      rh = pick_half();
      ts = pick_half();
    end
    send_request(rw, rh, ts, keep_start);
  endtask

  // One random phase: bursts with random gaps, and some runs with no gaps
  task automatic random_phase(int count);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        random_request((i + 1 < burst) && (sent + 1 < count));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic random_hints();
    write_hint(REG_HINT_FLAGS, 32'($urandom_range(0, 31)));
    write_hint(REG_MIN_SIZE, {16'($urandom_range(0, 300)), 16'($urandom_range(0, 300))});
    write_hint(REG_BASE_SIZE, {16'($urandom_range(0, 100)), 16'($urandom_range(0, 100))});
    write_hint(REG_HINT_MAX, {16'($urandom_range(100, 4000)), 16'($urandom_range(100, 4000))});
    write_hint(REG_SCREEN_MAX, $urandom_range(0, 4) == 0 ? pick_pair() :
               {16'($urandom_range(200, 4000)), 16'($urandom_range(200, 4000))});
    write_hint(REG_INCREMENT, {16'($urandom_range(0, 40)), 16'($urandom_range(0, 40))});
    write_hint(REG_MIN_ASPECT, {16'($urandom_range(0, 20)), 16'($urandom_range(0, 20))});
    write_hint(REG_MAX_ASPECT, {16'($urandom_range(0, 20)), 16'($urandom_range(0, 20))});
  endtask

  initial begin
    sizes_sb = new();
    sizes_sb.clear_regs();
    sizes_sb.mismatches = 0;
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_HINT_FLAGS;
    cfg_data = '0;
    req_width = '0;
    req_height = '0;
    title_size = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset hints: no flags, field extremes and title above the height
    send_request(16'h0000, 16'h0000, 16'h0000, 1);
    send_request(16'hffff, 16'hffff, 16'h0000, 1);
    send_request(16'hffff, 16'h0000, 16'hffff, 1);
    send_request(16'h5555, 16'haaaa, 16'h00ff, 0);
    drain_results();

    // All hints on: increment, both aspects, min, max and base
    write_hint(REG_HINT_FLAGS, 32'h1f);
    write_hint(REG_MIN_SIZE, 32'h0020_0030);
    write_hint(REG_BASE_SIZE, 32'h0008_000a);
    write_hint(REG_HINT_MAX, 32'h0400_0500);
    write_hint(REG_SCREEN_MAX, 32'h0300_0600);
    write_hint(REG_INCREMENT, 32'h0007_0005);
    write_hint(REG_MIN_ASPECT, 32'h0003_0004);
    write_hint(REG_MAX_ASPECT, 32'h0001_0002);
    send_request(16'd10, 16'd20, 16'd5, 1);
    send_request(16'd1000, 16'd50, 16'd10, 1);
    send_request(16'd60, 16'd900, 16'd10, 1);
    send_request(16'hffff, 16'hffff, 16'hffff, 0);
    drain_results();

    // Zero increments, a zero min aspect denominator and a zero max numerator
    write_hint(REG_INCREMENT, 32'h0000_0000);
    write_hint(REG_MIN_ASPECT, 32'h0000_0005);
    write_hint(REG_MAX_ASPECT, 32'h0003_0000);
    send_request(16'd500, 16'd30, 16'd2, 1);
    send_request(16'd30, 16'd500, 16'd2, 0);
    drain_results();

    // Aspect corrections that break the other bound; base size without min size
    write_hint(REG_HINT_FLAGS, 32'h1a);
    write_hint(REG_MIN_ASPECT, 32'h0001_0010);
    write_hint(REG_MAX_ASPECT, 32'h0010_0001);
    write_hint(REG_SCREEN_MAX, 32'h0040_0040);
    send_request(16'd64, 16'd2, 16'd0, 1);
    send_request(16'd2, 16'd64, 16'd0, 1);
    send_request(16'd0, 16'd0, 16'd100, 0);
    drain_results();

    // Extreme register values, then min size only
    write_hint(REG_HINT_FLAGS, 32'hffff_ffff);
    write_hint(REG_MIN_SIZE, 32'hffff_ffff);
    write_hint(REG_BASE_SIZE, 32'hffff_ffff);
    write_hint(REG_HINT_MAX, 32'h0000_0000);
    write_hint(REG_SCREEN_MAX, 32'hffff_ffff);
    write_hint(REG_INCREMENT, 32'hffff_ffff);
    write_hint(REG_MIN_ASPECT, 32'hffff_ffff);
    write_hint(REG_MAX_ASPECT, 32'hffff_ffff);
    send_request(16'd100, 16'd100, 16'd1, 1);
    send_request(16'hffff, 16'h0001, 16'h8000, 0);
    drain_results();
    write_hint(REG_HINT_FLAGS, 32'h01);
    write_hint(REG_HINT_MAX, 32'hffff_ffff);
    send_request(16'h8000, 16'h8000, 16'h7fff, 0);
    drain_results();

    // Random phases under fresh hints; the drain between phases is also
    // the sender pausing until every expected result has come
    for (int p = 0; p < 12; p++) begin
      random_hints();
      random_phase(100);
      drain_results();
    end
    // Back to reset-like hints with random requests
    sizes_sb.clear_regs();
    for (int r = 0; r < 8; r++) write_hint(cfg_reg_t'(r), sizes_sb.regs[r]);
    random_phase(50);
    drain_results();

    if (sizes_sb.mismatches == 0 && sizes_sb.pending_sizes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
